// ===== sv/sscp_pkg.sv =====
// ----------------------------------------------------------------------------
// sscp_pkg
// Shared constants for the segment closest-points pipeline.
// ----------------------------------------------------------------------------
package sscp_pkg;

    // limb width of the split multipliers
    localparam int LIMB_W = 32;

    // width of the saturating squared-distance field
    localparam int DIST_W = 50;

    // number of coordinate fields in one input word
    localparam int N_COORD = 12;

endpackage

// ===== sv/sscp_delay.sv =====
// ----------------------------------------------------------------------------
// sscp_delay
// Plain delay line that advances on the pipeline enable.
// ----------------------------------------------------------------------------
module sscp_delay #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  logic         aclk,
    input  logic         ce,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);

    logic [W-1:0] dly_reg [DEPTH];

    // shift one place per enabled cycle
    always_ff @(posedge aclk) begin
        if (ce) begin
            dly_reg[0] <= d;
            for (int i = 1; i < DEPTH; i++) begin
                dly_reg[i] <= dly_reg[i-1];
            end
        end
    end

    assign q = dly_reg[DEPTH-1];

endmodule

// ===== sv/sscp_mul.sv =====
// ----------------------------------------------------------------------------
// sscp_mul
// Wide signed multiplier split into limb products, three register stages:
// limb products, row sums, final sum.
// ----------------------------------------------------------------------------
module sscp_mul #(
    parameter int WA = 32,
    parameter int WB = 32
) (
    input  logic                    aclk,
    input  logic                    ce,
    input  logic signed [WA-1:0]    a,
    input  logic signed [WB-1:0]    b,
    output logic signed [WA+WB-1:0] p
);

    localparam int W  = WA + WB;
    localparam int L  = sscp_pkg::LIMB_W;
    localparam int N  = (W + L - 1) / L;
    localparam int XW = N * L;

    logic [XW-1:0]  ax;
    logic [XW-1:0]  bx;
    logic [2*L-1:0] pp_next  [N][N];
    logic [2*L-1:0] pp_reg   [N][N];
    logic [W-1:0]   row_next [N];
    logic [W-1:0]   row_reg  [N];
    logic [W-1:0]   sum_next;
    logic [W-1:0]   sum_reg;

    // sign-extend to whole limbs; the product is exact modulo 2^W
    assign ax = XW'(a);
    assign bx = XW'(b);

    // limb products, only those that reach below bit W
    always_comb begin
        for (int i = 0; i < N; i++) begin
            for (int j = 0; j < N; j++) begin
                if (i + j < N) begin
                    pp_next[i][j] = ax[i*L +: L] * bx[j*L +: L];
                end else begin
                    pp_next[i][j] = '0;
                end
            end
        end
    end

    // one row per limb of a
    always_comb begin
        for (int i = 0; i < N; i++) begin
            row_next[i] = '0;
            for (int j = 0; j < N; j++) begin
                if (i + j < N) begin
                    row_next[i] = row_next[i] + (W'(pp_reg[i][j]) << (j * L));
                end
            end
        end
    end

    // rows together
    always_comb begin
        sum_next = '0;
        for (int i = 0; i < N; i++) begin
            sum_next = sum_next + (row_reg[i] << (i * L));
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            pp_reg  <= pp_next;
            row_reg <= row_next;
            sum_reg <= sum_next;
        end
    end

    assign p = $signed(sum_reg);

endmodule

// ===== sv/sscp_ratio.sv =====
// ----------------------------------------------------------------------------
// sscp_ratio
// Clamped quotient num/den in [0,1] as unsigned Q1.FB, one restoring
// division step per stage; den is taken as positive.
// ----------------------------------------------------------------------------
module sscp_ratio #(
    parameter int W  = 16,
    parameter int FB = 8
) (
    input  logic                aclk,
    input  logic                ce,
    input  logic signed [W-1:0] num,
    input  logic signed [W-1:0] den,
    output logic [FB:0]         q
);

    logic [W:0]   rem_next  [FB+1];
    logic [W:0]   rem_reg   [FB+1];
    logic [W:0]   den_next  [FB+1];
    logic [W:0]   den_reg   [FB+1];
    logic [FB:0]  q_next    [FB+1];
    logic [FB:0]  q_reg     [FB+1];
    logic         done_next [FB+1];
    logic         done_reg  [FB+1];
    logic [W:0]   sh;

    always_comb begin
        sh = '0;
        // entry: quotient at or below zero, or at or above one
        den_next[0] = {1'b0, den};
        rem_next[0] = '0;
        q_next[0]   = '0;
        done_next[0] = 1'b1;
        if (num <= 0) begin
            q_next[0] = '0;
        end else if (num >= den) begin
            q_next[0] = (FB+1)'(1) << FB;
        end else begin
            rem_next[0]  = {1'b0, num};
            done_next[0] = 1'b0;
        end
        // one quotient bit per stage
        for (int k = 1; k <= FB; k++) begin
            sh           = rem_reg[k-1] << 1;
            den_next[k]  = den_reg[k-1];
            done_next[k] = done_reg[k-1];
            rem_next[k]  = rem_reg[k-1];
            q_next[k]    = q_reg[k-1];
            if (!done_reg[k-1]) begin
                if (sh >= den_reg[k-1]) begin
                    rem_next[k] = sh - den_reg[k-1];
                    q_next[k]   = {q_reg[k-1][FB-1:0], 1'b1};
                end else begin
                    rem_next[k] = sh;
                    q_next[k]   = {q_reg[k-1][FB-1:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            rem_reg  <= rem_next;
            den_reg  <= den_next;
            q_reg    <= q_next;
            done_reg <= done_next;
        end
    end

    assign q = q_reg[FB];

endmodule

// ===== sv/segment_segment_closest_points.sv =====
// ----------------------------------------------------------------------------
// segment_segment_closest_points
// Closest points of two 3D segments in fixed point, fully pipelined.
// ----------------------------------------------------------------------------
// One segment pair is taken per clock while the pipeline is not held. The
// result word passes through the two chained restoring dividers (one stage
// per quotient bit, for s and then for t) and the three-stage split
// multipliers in front of each. The whole pipeline advances together: it
// holds while a result waits on m_axis_tready, and s_axis_tready follows that
// enable. Coordinates are signed Q(COORD_WIDTH-FRAC_BITS).FRAC_BITS; s and t
// are unsigned Q1.FRAC_BITS and the squared distance saturates at 2^50-1.
// ----------------------------------------------------------------------------
module segment_segment_closest_points #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // a_start_x/y/z, a_end_x/y/z, b_start_x/y/z, b_end_x/y/z
    input  logic [((12*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // param_a, param_b, near_a_x/y/z, near_b_x/y/z, dist_squared
    output logic [((2*(FRAC_BITS+1)+6*COORD_WIDTH+50+7)/8)*8-1:0] m_axis_tdata
);

    localparam int CW    = COORD_WIDTH;
    localparam int FB    = FRAC_BITS;
    localparam int NC    = sscp_pkg::N_COORD;
    localparam int DSW   = sscp_pkg::DIST_W;
    localparam int DFW   = CW + 1;
    localparam int DW    = 2 * CW + 5;
    localparam int PW    = 2 * DW + 1;
    localparam int AW    = DW + 1;
    localparam int QW    = FB + 1;
    localparam int BSW   = DW + QW + 1;
    localparam int TW    = DW + FB + 3;
    localparam int PRW   = DFW + QW + 1;
    localparam int SW    = 2 * CW + 4;
    localparam int EW    = (SW > DSW) ? SW : DSW + 1;
    localparam int GW    = 6 * CW + 6 * DFW;
    localparam int LAT   = 2 * FB + 19;
    localparam int OUT_W = ((2*QW + 6*CW + DSW + 7) / 8) * 8;

    localparam logic [PRW-1:0] HALF_P = PRW'(1) << (FB - 1);
    localparam logic [SW-1:0]  HALF_D = SW'(1) << (FB - 1);
    localparam logic [QW-1:0]  ONE_Q  = QW'(1) << FB;

    // ---------------- handshake and valid chain ----------------
    logic           ce;
    logic [LAT-1:0] vld_reg;

    assign ce            = !vld_reg[LAT-1] || m_axis_tready;
    assign s_axis_tready = ce;
    assign m_axis_tvalid = vld_reg[LAT-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (ce) begin
            vld_reg <= {vld_reg[LAT-2:0], s_axis_tvalid};
        end
    end

    // ---------------- stage 1: input word ----------------
    logic signed [CW-1:0] crd_reg [NC];

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int k = 0; k < NC; k++) begin
                crd_reg[k] <= $signed(s_axis_tdata[k*CW +: CW]);
            end
        end
    end

    // ---------------- stage 2: direction and offset vectors ----------------
    logic signed [DFW-1:0] d1_reg [3];
    logic signed [DFW-1:0] d2_reg [3];
    logic signed [DFW-1:0] r_reg  [3];
    logic signed [CW-1:0]  p1_reg [3];
    logic signed [CW-1:0]  p2_reg [3];

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int k = 0; k < 3; k++) begin
                d1_reg[k] <= DFW'(crd_reg[3+k]) - DFW'(crd_reg[k]);
                d2_reg[k] <= DFW'(crd_reg[9+k]) - DFW'(crd_reg[6+k]);
                r_reg[k]  <= DFW'(crd_reg[k])   - DFW'(crd_reg[6+k]);
                p1_reg[k] <= crd_reg[k];
                p2_reg[k] <= crd_reg[6+k];
            end
        end
    end

    // ---------------- stage 3: per-axis products ----------------
    logic signed [2*DFW-1:0] pa_reg [3];
    logic signed [2*DFW-1:0] pe_reg [3];
    logic signed [2*DFW-1:0] pf_reg [3];
    logic signed [2*DFW-1:0] pc_reg [3];
    logic signed [2*DFW-1:0] pb_reg [3];

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int k = 0; k < 3; k++) begin
                pa_reg[k] <= d1_reg[k] * d1_reg[k];
                pe_reg[k] <= d2_reg[k] * d2_reg[k];
                pf_reg[k] <= d2_reg[k] * r_reg[k];
                pc_reg[k] <= d1_reg[k] * r_reg[k];
                pb_reg[k] <= d1_reg[k] * d2_reg[k];
            end
        end
    end

    // ---------------- stage 4: dot products ----------------
    logic signed [DW-1:0] a_reg, e_reg, f_reg, c_reg, b_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            a_reg <= DW'(pa_reg[0]) + DW'(pa_reg[1]) + DW'(pa_reg[2]);
            e_reg <= DW'(pe_reg[0]) + DW'(pe_reg[1]) + DW'(pe_reg[2]);
            f_reg <= DW'(pf_reg[0]) + DW'(pf_reg[1]) + DW'(pf_reg[2]);
            c_reg <= DW'(pc_reg[0]) + DW'(pc_reg[1]) + DW'(pc_reg[2]);
            b_reg <= DW'(pb_reg[0]) + DW'(pb_reg[1]) + DW'(pb_reg[2]);
        end
    end

    // ---------------- cross products for the s numerator/denominator -----------
    logic signed [2*DW-1:0] ae, bb, bf, cxe;

    sscp_mul #(.WA(DW), .WB(DW)) u_mul_ae (
        .aclk(aclk), .ce(ce), .a(a_reg), .b(e_reg), .p(ae));
    sscp_mul #(.WA(DW), .WB(DW)) u_mul_bb (
        .aclk(aclk), .ce(ce), .a(b_reg), .b(b_reg), .p(bb));
    sscp_mul #(.WA(DW), .WB(DW)) u_mul_bf (
        .aclk(aclk), .ce(ce), .a(b_reg), .b(f_reg), .p(bf));
    sscp_mul #(.WA(DW), .WB(DW)) u_mul_ce (
        .aclk(aclk), .ce(ce), .a(c_reg), .b(e_reg), .p(cxe));

    // parallel segments take a zero numerator, hence s = 0
    logic signed [PW-1:0] den_reg, num_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            den_reg <= PW'(ae) - PW'(bb);
            if (ae == bb) begin
                num_reg <= '0;
            end else begin
                num_reg <= PW'(bf) - PW'(cxe);
            end
        end
    end

    // ---------------- divider for s ----------------
    logic [QW-1:0] s_raw;

    sscp_ratio #(.W(PW), .FB(FB)) u_div_s (
        .aclk(aclk), .ce(ce), .num(num_reg), .den(den_reg), .q(s_raw));

    // ---------------- fallback quotients, from the dot products ----------------
    logic signed [AW-1:0] neg_c, b_min_c, a_ext, f_ext, e_ext;
    logic [QW-1:0]        s_lo, s_hi, t_pt;

    assign neg_c   = -AW'(c_reg);
    assign b_min_c = AW'(b_reg) - AW'(c_reg);
    assign a_ext   = AW'(a_reg);
    assign f_ext   = AW'(f_reg);
    assign e_ext   = AW'(e_reg);

    sscp_ratio #(.W(AW), .FB(FB)) u_div_lo (
        .aclk(aclk), .ce(ce), .num(neg_c), .den(a_ext), .q(s_lo));
    sscp_ratio #(.W(AW), .FB(FB)) u_div_hi (
        .aclk(aclk), .ce(ce), .num(b_min_c), .den(a_ext), .q(s_hi));
    sscp_ratio #(.W(AW), .FB(FB)) u_div_pt (
        .aclk(aclk), .ce(ce), .num(f_ext), .den(e_ext), .q(t_pt));

    // ---------------- side paths ----------------
    logic [DW-1:0]     b_d;
    logic [2*DW-1:0]   fe_d;
    logic [1:0]        deg_d;
    logic [3*QW-1:0]   alt_d;
    logic [QW-1:0]     s_d;
    logic [1:0]        tflag_d;
    logic [GW-1:0]     geo_in, geo_d;

    sscp_delay #(.W(DW), .DEPTH(FB+5)) u_dly_b (
        .aclk(aclk), .ce(ce), .d(b_reg), .q(b_d));
    sscp_delay #(.W(2*DW), .DEPTH(FB+8)) u_dly_fe (
        .aclk(aclk), .ce(ce), .d({f_reg, e_reg}), .q(fe_d));
    sscp_delay #(.W(2), .DEPTH(2*FB+10)) u_dly_deg (
        .aclk(aclk), .ce(ce), .d({a_reg == '0, e_reg == '0}), .q(deg_d));
    sscp_delay #(.W(3*QW), .DEPTH(FB+9)) u_dly_alt (
        .aclk(aclk), .ce(ce), .d({s_lo, s_hi, t_pt}), .q(alt_d));
    sscp_delay #(.W(QW), .DEPTH(FB+5)) u_dly_s (
        .aclk(aclk), .ce(ce), .d(s_raw), .q(s_d));

    // geometry rides alongside until the point stage
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            geo_in[k*CW +: CW]                 = p1_reg[k];
            geo_in[(3+k)*CW +: CW]             = p2_reg[k];
            geo_in[6*CW + k*DFW +: DFW]        = d1_reg[k];
            geo_in[6*CW + (3+k)*DFW +: DFW]    = d2_reg[k];
        end
    end

    sscp_delay #(.W(GW), .DEPTH(2*FB+13)) u_dly_geo (
        .aclk(aclk), .ce(ce), .d(geo_in), .q(geo_d));

    // ---------------- t numerator: b*s + f<<FB ----------------
    logic signed [BSW-1:0] bs;
    logic signed [TW-1:0]  tn_reg, td_reg;

    sscp_mul #(.WA(DW), .WB(QW+1)) u_mul_bs (
        .aclk(aclk), .ce(ce), .a($signed(b_d)), .b($signed({1'b0, s_raw})), .p(bs));

    always_ff @(posedge aclk) begin
        if (ce) begin
            tn_reg <= TW'(bs) + (TW'($signed(fe_d[2*DW-1:DW])) <<< FB);
            td_reg <= TW'($signed(fe_d[DW-1:0])) <<< FB;
        end
    end

    sscp_delay #(.W(2), .DEPTH(FB+1)) u_dly_tf (
        .aclk(aclk), .ce(ce), .d({tn_reg[TW-1], td_reg < tn_reg}), .q(tflag_d));

    // ---------------- divider for t ----------------
    logic [QW-1:0] t_raw;

    sscp_ratio #(.W(TW), .FB(FB)) u_div_t (
        .aclk(aclk), .ce(ce), .num(tn_reg), .den(td_reg), .q(t_raw));

    // ---------------- pick s and t by case ----------------
    logic [QW-1:0] s_c_reg, t_c_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            priority if (deg_d[1] && deg_d[0]) begin
                s_c_reg <= '0;
                t_c_reg <= '0;
            end else if (deg_d[1]) begin
                s_c_reg <= '0;
                t_c_reg <= alt_d[QW-1:0];
            end else if (deg_d[0]) begin
                s_c_reg <= alt_d[3*QW-1:2*QW];
                t_c_reg <= '0;
            end else if (tflag_d[1]) begin
                s_c_reg <= alt_d[3*QW-1:2*QW];
                t_c_reg <= '0;
            end else if (tflag_d[0]) begin
                s_c_reg <= alt_d[2*QW-1:QW];
                t_c_reg <= ONE_Q;
            end else begin
                s_c_reg <= s_d;
                t_c_reg <= t_raw;
            end
        end
    end

    // ---------------- point offsets ----------------
    logic signed [PRW-1:0] pra_reg [3];
    logic signed [PRW-1:0] prb_reg [3];
    logic signed [CW-1:0]  p1p_reg [3];
    logic signed [CW-1:0]  p2p_reg [3];
    logic [QW-1:0]         s_p_reg, t_p_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int k = 0; k < 3; k++) begin
                pra_reg[k] <= $signed(geo_d[6*CW + k*DFW +: DFW])
                              * $signed({1'b0, s_c_reg});
                prb_reg[k] <= $signed(geo_d[6*CW + (3+k)*DFW +: DFW])
                              * $signed({1'b0, t_c_reg});
                p1p_reg[k] <= $signed(geo_d[k*CW +: CW]);
                p2p_reg[k] <= $signed(geo_d[(3+k)*CW +: CW]);
            end
            s_p_reg <= s_c_reg;
            t_p_reg <= t_c_reg;
        end
    end

    // ---------------- closest points, rounded half up ----------------
    logic signed [CW-1:0] na_reg [3];
    logic signed [CW-1:0] nb_reg [3];
    logic [QW-1:0]        s_n_reg, t_n_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int k = 0; k < 3; k++) begin
                na_reg[k] <= CW'(PRW'(p1p_reg[k]) + ((pra_reg[k] + $signed(HALF_P)) >>> FB));
                nb_reg[k] <= CW'(PRW'(p2p_reg[k]) + ((prb_reg[k] + $signed(HALF_P)) >>> FB));
            end
            s_n_reg <= s_p_reg;
            t_n_reg <= t_p_reg;
        end
    end

    // ---------------- squared differences ----------------
    logic signed [CW:0]    dif [3];
    logic [2*CW+1:0]       sq_reg [3];
    logic signed [CW-1:0]  na_q_reg [3];
    logic signed [CW-1:0]  nb_q_reg [3];
    logic [QW-1:0]         s_q_reg, t_q_reg;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            dif[k] = (CW+1)'(na_reg[k]) - (CW+1)'(nb_reg[k]);
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int k = 0; k < 3; k++) begin
                sq_reg[k] <= $unsigned((2*CW+2)'(dif[k] * dif[k]));
            end
            na_q_reg <= na_reg;
            nb_q_reg <= nb_reg;
            s_q_reg  <= s_n_reg;
            t_q_reg  <= t_n_reg;
        end
    end

    // ---------------- distance and output word ----------------
    logic [SW-1:0]  sum_sq, rnd;
    logic [EW-1:0]  rnd_e;
    logic [DSW-1:0] dist_sat;
    logic [OUT_W-1:0] out_next, out_reg;

    always_comb begin
        sum_sq = SW'(sq_reg[0]) + SW'(sq_reg[1]) + SW'(sq_reg[2]);
        rnd    = (sum_sq + HALF_D) >> FB;
        rnd_e  = EW'(rnd);
        if (rnd_e[EW-1:DSW] != '0) begin
            dist_sat = '1;
        end else begin
            dist_sat = rnd_e[DSW-1:0];
        end
        out_next = '0;
        out_next[0 +: QW]  = s_q_reg;
        out_next[QW +: QW] = t_q_reg;
        for (int k = 0; k < 3; k++) begin
            out_next[2*QW + k*CW +: CW]     = na_q_reg[k];
            out_next[2*QW + (3+k)*CW +: CW] = nb_q_reg[k];
        end
        out_next[2*QW + 6*CW +: DSW] = dist_sat;
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            out_reg <= out_next;
        end
    end

    assign m_axis_tdata = out_reg;

endmodule

// ===== tb/sv/sscp_checker.sv =====
// ----------------------------------------------------------------------------
// sscp_checker
// Watches both streams of the segment closest-points block. For each input
// word it computes the expected closest points, and it compares each result
// word with the oldest expected one.
// ----------------------------------------------------------------------------
module sscp_checker (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [383:0] s_axis_tdata,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [279:0] m_axis_tdata,
    output int           fail_count,
    output int           pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FB   = 16;
    localparam int CW   = 32;
    localparam int PW   = FB + 1;
    localparam int DSTW = sscp_pkg::DIST_W;

    typedef logic signed [255:0] wide_t;

    typedef struct packed {
        logic [PW-1:0]       s;
        logic [PW-1:0]       t;
        logic [2:0][CW-1:0]  na;
        logic [2:0][CW-1:0]  nb;
        logic [DSTW-1:0]     dsq;
    } closest_t;

    closest_t closest_q[$];

    // clamp(num/den) to [0,1] as floor(q * 2^FB); den is positive
    function automatic logic [PW-1:0] clamp_quot(wide_t num, wide_t den);
        wide_t q;
        if (num <= 0) return '0;
        if (num >= den) return PW'(1) << FB;
        q = (num <<< FB) / den;
        return q[PW-1:0];
    endfunction

    function automatic wide_t dot(wide_t x[3], wide_t y[3]);
        return x[0] * y[0] + x[1] * y[1] + x[2] * y[2];
    endfunction

    function automatic closest_t find_closest(logic [383:0] w);
        wide_t p1[3], q1[3], p2[3], q2[3], d1[3], d2[3], r[3];
        wide_t a, b, c, e, f, den, tn, td, sw, tw, half, sum, diff, n1, n2;
        logic [PW-1:0] s, t;
        closest_t res;
        for (int k = 0; k < 3; k++) begin
            p1[k] = wide_t'($signed(w[CW*k +: CW]));
            q1[k] = wide_t'($signed(w[CW*(3+k) +: CW]));
            p2[k] = wide_t'($signed(w[CW*(6+k) +: CW]));
            q2[k] = wide_t'($signed(w[CW*(9+k) +: CW]));
            d1[k] = q1[k] - p1[k];
            d2[k] = q2[k] - p2[k];
            r[k]  = p1[k] - p2[k];
        end
        a = dot(d1, d1);
        e = dot(d2, d2);
        f = dot(d2, r);
        c = dot(d1, r);
        b = dot(d1, d2);
        if (a == 0 && e == 0) begin
            s = '0;
            t = '0;
        end else if (a == 0) begin
            s = '0;
            t = clamp_quot(f, e);
        end else if (e == 0) begin
            t = '0;
            s = clamp_quot(-c, a);
        end else begin
            den = a * e - b * b;
            s = (den == 0) ? '0 : clamp_quot(b * f - c * e, den);
            sw = wide_t'({239'b0, s});
            tn = b * sw + (f <<< FB);
            td = e <<< FB;
            if (tn < 0) begin
                t = '0;
                s = clamp_quot(-c, a);
            end else if (td < tn) begin
                t = PW'(1) << FB;
                s = clamp_quot(b - c, a);
            end else begin
                t = clamp_quot(tn, td);
            end
        end
        sw = wide_t'({239'b0, s});
        tw = wide_t'({239'b0, t});
        half = wide_t'(1) <<< (FB - 1);
        sum = 0;
        for (int k = 0; k < 3; k++) begin
            n1 = p1[k] + ((d1[k] * sw + half) >>> FB);
            n2 = p2[k] + ((d2[k] * tw + half) >>> FB);
            diff = n1 - n2;
            sum = sum + diff * diff;
            res.na[k] = n1[CW-1:0];
            res.nb[k] = n2[CW-1:0];
        end
        sum = (sum + half) >>> FB;
        res.s = s;
        res.t = t;
        // saturate the squared distance
        res.dsq = (sum < (wide_t'(1) <<< DSTW)) ? sum[DSTW-1:0] : {DSTW{1'b1}};
        return res;
    endfunction

    function automatic closest_t unpack_result(logic [279:0] w);
        closest_t r;
        r.s = w[0 +: PW];
        r.t = w[PW +: PW];
        for (int k = 0; k < 3; k++) begin
            r.na[k] = w[2*PW + CW*k +: CW];
            r.nb[k] = w[2*PW + CW*(3+k) +: CW];
        end
        r.dsq = w[2*PW + 6*CW +: DSTW];
        return r;
    endfunction

    assign pending = closest_q.size();

    // predict on input words, compare on result words
    always @(posedge aclk) begin
        closest_t got, want;
        if (aresetn) begin
            if (s_axis_tvalid && s_axis_tready)
                closest_q = {closest_q, find_closest(s_axis_tdata)};
            if (m_axis_tvalid && m_axis_tready) begin
                got = unpack_result(m_axis_tdata);
                if (closest_q.size() == 0) begin
                    $error("result word with nothing expected");
                    fail_count++;
                end else begin
                    want = closest_q.pop_front();
                    if (got.s !== want.s) begin
                        $error("param_a: expected %0d, got %0d", want.s, got.s);
                        fail_count++;
                    end
                    if (got.t !== want.t) begin
                        $error("param_b: expected %0d, got %0d", want.t, got.t);
                        fail_count++;
                    end
                    for (int k = 0; k < 3; k++) begin
                        if (got.na[k] !== want.na[k]) begin
                            $error("near_a[%0d]: expected %h, got %h",
                                   k, want.na[k], got.na[k]);
                            fail_count++;
                        end
                        if (got.nb[k] !== want.nb[k]) begin
                            $error("near_b[%0d]: expected %h, got %h",
                                   k, want.nb[k], got.nb[k]);
                            fail_count++;
                        end
                    end
                    if (got.dsq !== want.dsq) begin
                        $error("dist_squared: expected %0d, got %0d", want.dsq, got.dsq);
                        fail_count++;
                    end
                end
            end
        end
    end

endmodule

// ===== tb/sv/tb_segment_segment_closest_points.sv =====
// ----------------------------------------------------------------------------
// tb_segment_segment_closest_points
// Drives segment pairs into the closest-points block: directed corner cases,
// then random pairs with random gaps and stalls on both streams. The checker
// beside the block does all prediction and comparison.
// ----------------------------------------------------------------------------
module tb_segment_segment_closest_points;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_RANDOM = 1430;
    localparam logic [31:0] CMAX = 32'h7fff_ffff;
    localparam logic [31:0] CMIN = 32'h8000_0000;

    logic         aclk;
    logic         aresetn;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [383:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [279:0] m_axis_tdata;
    int           fail_count;
    int           pending;
    int           words_sent;
    bit           hold_off_done;

    segment_segment_closest_points uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),  // a_start xyz, a_end xyz, b_start xyz, b_end xyz
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)   // param_a, param_b, near_a xyz, near_b xyz, dist_squared
    );

    sscp_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 45) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [31:0] rand_coord(int mode);
        case (mode)
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 2 ** 21)) - 2 ** 20);
            default: return 32'($signed($urandom_range(0, 2 ** 13)) - 2 ** 12);
        endcase
    endfunction

    function automatic logic [383:0] pair_word(logic [31:0] c[12]);
        logic [383:0] w;
        for (int k = 0; k < 12; k++) w[32*k +: 32] = c[k];
        return w;
    endfunction

    // one segment pair, mostly well formed, some degenerate or parallel
    function automatic logic [383:0] random_pair();
        logic [31:0] c[12];
        int mode, kind, m;
        mode = $urandom_range(0, 9) < 2 ? 0 : ($urandom_range(0, 1) ? 1 : 2);
        kind = $urandom_range(0, 9);
        for (int k = 0; k < 12; k++) c[k] = rand_coord(mode);
        case (kind)
            0: for (int k = 0; k < 3; k++) c[3+k] = c[k];
            1: for (int k = 0; k < 3; k++) c[9+k] = c[6+k];
            2: for (int k = 0; k < 3; k++) begin
                c[3+k] = c[k];
                c[9+k] = c[6+k];
            end
            3: begin
                m = $urandom_range(1, 3);
                for (int k = 0; k < 3; k++) begin
                    c[k] = rand_coord(2);
                    c[3+k] = c[k] + rand_coord(2);
                    c[6+k] = rand_coord(2);
                    c[9+k] = c[6+k] - m * (c[3+k] - c[k]);
                end
            end
            default: ;
        endcase
        return pair_word(c);
    endfunction

    task automatic send_pair(logic [383:0] w);
        int g;
        g = gap_len();
        if (g > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= w;
        forever begin
            @(negedge aclk);
            if (s_axis_tready) break;
        end
        @(posedge aclk);
        words_sent++;
    endtask

    task automatic send_coords(logic [31:0] c[12]);
        send_pair(pair_word(c));
    endtask

    // result side: random stalls, one long hold-off while the sender runs on
    initial begin
        int n;
        m_axis_tready = 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            if (!hold_off_done && words_sent > 300) begin
                hold_off_done = 1'b1;
                m_axis_tready <= 1'b0;
                n = 0;
                while (n < 400) begin
                    @(posedge aclk);
                    n++;
                end
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge aclk);
            n = gap_len();
            if (n > 0) begin
                m_axis_tready <= 1'b0;
                repeat (n) @(posedge aclk);
            end
        end
    end

    initial begin
        #5ms;
        $display("FAILURE");
        $finish;
    end

    initial begin
        logic [31:0] c[12];
        int guard;
        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        words_sent    = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // both segments collapse to points, all zero
        foreach (c[k]) c[k] = 32'h0;
        send_coords(c);
        // both points, apart
        c = '{32'h10000, 32'h20000, 32'h30000, 32'h10000, 32'h20000, 32'h30000,
              32'h50000, 32'h0, 32'hffff0000, 32'h50000, 32'h0, 32'hffff0000};
        send_coords(c);
        // first segment a point, projection inside, before and beyond
        c = '{32'h8000, 32'h10000, 32'h0, 32'h8000, 32'h10000, 32'h0,
              32'h0, 32'h0, 32'h0, 32'h10000, 32'h0, 32'h0};
        send_coords(c);
        c[0] = 32'hfffe0000; c[3] = 32'hfffe0000;
        send_coords(c);
        c[0] = 32'h30000; c[3] = 32'h30000;
        send_coords(c);
        // second segment a point, inside and clamped
        c = '{32'h0, 32'h0, 32'h0, 32'h40000, 32'h0, 32'h0,
              32'h18000, 32'h10000, 32'h0, 32'h18000, 32'h10000, 32'h0};
        send_coords(c);
        c[6] = 32'hfff00000; c[9] = 32'hfff00000;
        send_coords(c);
        c[6] = 32'h00500000; c[9] = 32'h00500000;
        send_coords(c);
        // parallel segments, overlapping and disjoint
        c = '{32'h0, 32'h0, 32'h0, 32'h20000, 32'h0, 32'h0,
              32'h10000, 32'h10000, 32'h0, 32'h30000, 32'h10000, 32'h0};
        send_coords(c);
        c = '{32'h0, 32'h0, 32'h0, 32'h20000, 32'h0, 32'h0,
              32'h50000, 32'h10000, 32'h0, 32'h40000, 32'h10000, 32'h0};
        send_coords(c);
        // crossing, t below zero, t above one
        c = '{32'h0, 32'h0, 32'h0, 32'h20000, 32'h0, 32'h0,
              32'h10000, 32'hffff0000, 32'h10000, 32'h10000, 32'h10000, 32'h10000};
        send_coords(c);
        c = '{32'h0, 32'h0, 32'h0, 32'h20000, 32'h0, 32'h0,
              32'h10000, 32'h30000, 32'h0, 32'h10000, 32'h50000, 32'h0};
        send_coords(c);
        c = '{32'h0, 32'h0, 32'h0, 32'h20000, 32'h0, 32'h0,
              32'h10000, 32'hfffb0000, 32'h0, 32'h10000, 32'hfffd0000, 32'h0};
        send_coords(c);
        // extremes of the coordinate range, saturating distance
        foreach (c[k]) c[k] = (k < 6) ? CMAX : CMIN;
        send_coords(c);
        foreach (c[k]) c[k] = (k < 6) ? CMIN : CMAX;
        send_coords(c);
        foreach (c[k]) c[k] = ((k / 3) % 2) ? CMAX : CMIN;
        send_coords(c);
        foreach (c[k]) c[k] = (k % 2) ? CMAX : CMIN;
        send_coords(c);
        foreach (c[k]) c[k] = 32'hffff_ffff;
        send_coords(c);
        foreach (c[k]) c[k] = (k == 3 || k == 9) ? CMAX : 32'h0;
        send_coords(c);

        for (int i = 0; i < N_RANDOM; i++)
            send_pair(random_pair());
        s_axis_tvalid <= 1'b0;

        guard = 0;
        while (pending != 0 && guard < 200000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (60) @(posedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
